### sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants for the 3D segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int PARAM_FRAC_DEF  = 16;

	localparam int EPS_W = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	localparam int DIST_W = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = 25'h1FF_FFFF;

	// wide multiplier depth
	localparam int MUL_LAT = 5;

	// bit-serial root: 54-bit radicand, first trial bit 2^52, 27 steps
	localparam int SQRT_W     = 54;
	localparam int SQRT_TOP   = 52;
	localparam int SQRT_STEPS = 27;
	localparam int ROOT_W     = 27;

endpackage

### sv/segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d
// Shortest distance between two 3D line segments, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   is always low, so a new pair of segments may enter on every cycle.
//   The twelve coordinates are signed Q15.8 end points of both segments.
//   Each request gives one result: done pulses for one cycle with distance
//   (unsigned Q17.8, saturated) valid in that cycle. Results come out in
//   request order. The receiver cannot stall the pipeline.
//   The pipeline is made of 12 difference, dot product, wide product and
//   clamp stages, one stage per quotient bit plus one in the ratio units,
//   5 closing-vector stages, 27 root stages and the output register.
//   Throughput is one request per cycle.
//   cfg_we/cfg_wdata write the parallel threshold on the determinant; write
//   it only while no request is in flight. Reset empties the pipeline and
//   sets the threshold to 1.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d #(
	parameter int COORD_WIDTH         = ssd_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRACTION_BITS = ssd_pkg::PARAM_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [ssd_pkg::EPS_W-1:0]         cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0]     seg1_start_x,
	input  logic signed [COORD_WIDTH-1:0]     seg1_start_y,
	input  logic signed [COORD_WIDTH-1:0]     seg1_start_z,
	input  logic signed [COORD_WIDTH-1:0]     seg1_end_x,
	input  logic signed [COORD_WIDTH-1:0]     seg1_end_y,
	input  logic signed [COORD_WIDTH-1:0]     seg1_end_z,
	input  logic signed [COORD_WIDTH-1:0]     seg2_start_x,
	input  logic signed [COORD_WIDTH-1:0]     seg2_start_y,
	input  logic signed [COORD_WIDTH-1:0]     seg2_start_z,
	input  logic signed [COORD_WIDTH-1:0]     seg2_end_x,
	input  logic signed [COORD_WIDTH-1:0]     seg2_end_y,
	input  logic signed [COORD_WIDTH-1:0]     seg2_end_z,
	output logic                              done,
	output logic [ssd_pkg::DIST_W-1:0]        distance
);

	localparam int F       = PARAM_FRACTION_BITS;
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int MUL_W   = 2 * DOT_W;
	localparam int WIDE_W  = MUL_W + 1;
	localparam int PR_W    = F + 2 + DIFF_W;
	localparam int CMP_W   = DIFF_W + F + 3;
	localparam int MAG_W   = CMP_W - F + 1;
	localparam int DIST_W  = ssd_pkg::DIST_W;
	localparam int MAGX_W  = (MAG_W > DIST_W + 1) ? MAG_W : DIST_W + 1;
	localparam int SQ_W    = 2 * DIST_W;
	localparam int SQRT_W  = ssd_pkg::SQRT_W;
	localparam int E_LAT   = 12;
	localparam int DIV_LAT = F + 1;
	localparam int UVW_LAT = E_LAT + DIV_LAT - 1;
	localparam int LAT     = E_LAT + DIV_LAT + 5 + ssd_pkg::SQRT_STEPS + 1;

	logic [ssd_pkg::EPS_W-1:0] eps_q;
	logic [LAT-1:0]            vld_q;
	logic [DIST_W-1:0]         distance_q;

	logic signed [COORD_WIDTH-1:0] p0 [3], p1 [3], q0 [3], q1 [3];

	assign p0[0] = seg1_start_x;  assign p0[1] = seg1_start_y;  assign p0[2] = seg1_start_z;
	assign p1[0] = seg1_end_x;    assign p1[1] = seg1_end_y;    assign p1[2] = seg1_end_z;
	assign q0[0] = seg2_start_x;  assign q0[1] = seg2_start_y;  assign q0[2] = seg2_start_z;
	assign q1[0] = seg2_end_x;    assign q1[1] = seg2_end_y;    assign q1[2] = seg2_end_z;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= ssd_pkg::EPS_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	// ---- differences, products, dot products
	logic signed [DIFF_W-1:0] u_s1 [3], v_s1 [3], w_s1 [3];
	logic signed [PROD_W-1:0] uu_s2 [3], uv_s2 [3], vv_s2 [3], uw_s2 [3], vw_s2 [3];
	logic signed [DOT_W-1:0]  a_s3, b_s3, c_s3, d_s3, e_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s1[i] <= DIFF_W'(p1[i]) - DIFF_W'(p0[i]);
			v_s1[i] <= DIFF_W'(q1[i]) - DIFF_W'(q0[i]);
			w_s1[i] <= DIFF_W'(p0[i]) - DIFF_W'(q0[i]);
			uu_s2[i] <= u_s1[i] * u_s1[i];
			uv_s2[i] <= u_s1[i] * v_s1[i];
			vv_s2[i] <= v_s1[i] * v_s1[i];
			uw_s2[i] <= u_s1[i] * w_s1[i];
			vw_s2[i] <= v_s1[i] * w_s1[i];
		end
		a_s3 <= DOT_W'(uu_s2[0]) + DOT_W'(uu_s2[1]) + DOT_W'(uu_s2[2]);
		b_s3 <= DOT_W'(uv_s2[0]) + DOT_W'(uv_s2[1]) + DOT_W'(uv_s2[2]);
		c_s3 <= DOT_W'(vv_s2[0]) + DOT_W'(vv_s2[1]) + DOT_W'(vv_s2[2]);
		d_s3 <= DOT_W'(uw_s2[0]) + DOT_W'(uw_s2[1]) + DOT_W'(uw_s2[2]);
		e_s3 <= DOT_W'(vw_s2[0]) + DOT_W'(vw_s2[1]) + DOT_W'(vw_s2[2]);
	end

	// ---- wide products
	logic signed [MUL_W-1:0] ac_s8, bb_s8, be_s8, cd_s8, ae_s8, bd_s8;
	logic signed [DOT_W-1:0] a_s8, b_s8, c_s8, d_s8, e_s8;

	ssd_mul #(.W(DOT_W)) u_mul_ac (.clk(clk), .a(a_s3), .b(c_s3), .p(ac_s8));
	ssd_mul #(.W(DOT_W)) u_mul_bb (.clk(clk), .a(b_s3), .b(b_s3), .p(bb_s8));
	ssd_mul #(.W(DOT_W)) u_mul_be (.clk(clk), .a(b_s3), .b(e_s3), .p(be_s8));
	ssd_mul #(.W(DOT_W)) u_mul_cd (.clk(clk), .a(c_s3), .b(d_s3), .p(cd_s8));
	ssd_mul #(.W(DOT_W)) u_mul_ae (.clk(clk), .a(a_s3), .b(e_s3), .p(ae_s8));
	ssd_mul #(.W(DOT_W)) u_mul_bd (.clk(clk), .a(b_s3), .b(d_s3), .p(bd_s8));

	ssd_delay #(.WIDTH(5*DOT_W), .DEPTH(ssd_pkg::MUL_LAT)) u_dly_dot (
		.clk(clk),
		.d  ({a_s3, b_s3, c_s3, d_s3, e_s3}),
		.q  ({a_s8, b_s8, c_s8, d_s8, e_s8})
	);

	// ---- determinant and numerators
	logic signed [WIDE_W-1:0] dt_s9, sn0_s9, tn0_s9, eb_s9, bmd_s9, nd_s9;
	logic signed [WIDE_W-1:0] a_s9, c_s9, e_s9;

	always_ff @(posedge clk) begin
		dt_s9  <= WIDE_W'(ac_s8) - WIDE_W'(bb_s8);
		sn0_s9 <= WIDE_W'(be_s8) - WIDE_W'(cd_s8);
		tn0_s9 <= WIDE_W'(ae_s8) - WIDE_W'(bd_s8);
		eb_s9  <= WIDE_W'(e_s8) + WIDE_W'(b_s8);
		bmd_s9 <= WIDE_W'(b_s8) - WIDE_W'(d_s8);
		nd_s9  <= WIDE_W'(0) - WIDE_W'(d_s8);
		a_s9   <= WIDE_W'(a_s8);
		c_s9   <= WIDE_W'(c_s8);
		e_s9   <= WIDE_W'(e_s8);
	end

	// ---- parallel test and s edge clamps
	logic signed [WIDE_W-1:0] sn_s10, sd_s10, tn_s10, td_s10, a_s10, bmd_s10, nd_s10;
	logic signed [WIDE_W-1:0] sn_e2, sd_e2, tn_e2, td_e2;

	always_comb begin
		if (dt_s9 < $signed(WIDE_W'(eps_q))) begin
			sn_e2 = '0;
			sd_e2 = WIDE_W'(1);
			tn_e2 = e_s9;
			td_e2 = c_s9;
		end else if (sn0_s9 < 0) begin
			sn_e2 = '0;
			sd_e2 = dt_s9;
			tn_e2 = e_s9;
			td_e2 = c_s9;
		end else if (sn0_s9 > dt_s9) begin
			sn_e2 = dt_s9;
			sd_e2 = dt_s9;
			tn_e2 = eb_s9;
			td_e2 = c_s9;
		end else begin
			sn_e2 = sn0_s9;
			sd_e2 = dt_s9;
			tn_e2 = tn0_s9;
			td_e2 = dt_s9;
		end
	end

	always_ff @(posedge clk) begin
		sn_s10  <= sn_e2;
		sd_s10  <= sd_e2;
		tn_s10  <= tn_e2;
		td_s10  <= td_e2;
		a_s10   <= a_s9;
		bmd_s10 <= bmd_s9;
		nd_s10  <= nd_s9;
	end

	// ---- t edge clamps
	logic signed [WIDE_W-1:0] sn_s11, sd_s11, tn_s11, td_s11, a_s11, x_s11;
	logic                     fix_s11;
	logic                     tneg, tgt;

	assign tneg = tn_s10 < 0;
	assign tgt  = tn_s10 > td_s10;

	always_ff @(posedge clk) begin
		sn_s11  <= sn_s10;
		sd_s11  <= sd_s10;
		td_s11  <= td_s10;
		a_s11   <= a_s10;
		fix_s11 <= tneg | tgt;
		x_s11   <= tneg ? nd_s10 : bmd_s10;
		tn_s11  <= tneg ? '0 : (tgt ? td_s10 : tn_s10);
	end

	logic signed [WIDE_W-1:0] sn_s12, sd_s12, tn_s12, td_s12;

	always_ff @(posedge clk) begin
		tn_s12 <= tn_s11;
		td_s12 <= td_s11;
		sn_s12 <= sn_s11;
		sd_s12 <= sd_s11;
		if (fix_s11) begin
			if (x_s11 < 0) begin
				sn_s12 <= '0;
			end else if (x_s11 > a_s11) begin
				sn_s12 <= sd_s11;
			end else begin
				sn_s12 <= x_s11;
				sd_s12 <= a_s11;
			end
		end
	end

	// ---- parameter ratios
	logic [F:0] sc, tc;

	ssd_div #(.W(WIDE_W), .F(F)) u_div_s (.clk(clk), .n(sn_s12), .d(sd_s12), .q(sc));
	ssd_div #(.W(WIDE_W), .F(F)) u_div_t (.clk(clk), .n(tn_s12), .d(td_s12), .q(tc));

	logic signed [DIFF_W-1:0] u_dv [3], v_dv [3], w_dv [3];

	ssd_delay #(.WIDTH(9*DIFF_W), .DEPTH(UVW_LAT)) u_dly_uvw (
		.clk(clk),
		.d  ({u_s1[0], u_s1[1], u_s1[2], v_s1[0], v_s1[1], v_s1[2],
		      w_s1[0], w_s1[1], w_s1[2]}),
		.q  ({u_dv[0], u_dv[1], u_dv[2], v_dv[0], v_dv[1], v_dv[2],
		      w_dv[0], w_dv[1], w_dv[2]})
	);

	// ---- closing vector
	logic signed [PR_W-1:0]   su_c1 [3], tv_c1 [3];
	logic signed [DIFF_W-1:0] w_c1 [3];
	logic signed [CMP_W-1:0]  comp_c2 [3];
	logic [DIST_W-1:0]        mag_c3 [3];
	logic                     sat_c3, sat_c4, sat_c5;
	logic [SQ_W-1:0]          sq_c4 [3];
	logic [SQRT_W-1:0]        sum_c5;
	logic [DIST_W-1:0]        mag_e3 [3];
	logic                     sat_e3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			su_c1[i]   <= $signed({1'b0, sc}) * u_dv[i];
			tv_c1[i]   <= $signed({1'b0, tc}) * v_dv[i];
			w_c1[i]    <= w_dv[i];
			comp_c2[i] <= (CMP_W'(w_c1[i]) <<< F) + CMP_W'(su_c1[i]) - CMP_W'(tv_c1[i]);
			mag_c3[i]  <= mag_e3[i];
			sq_c4[i]   <= mag_c3[i] * mag_c3[i];
		end
		sat_c3 <= sat_e3;
		sat_c4 <= sat_c3;
		sat_c5 <= sat_c4;
		sum_c5 <= SQRT_W'(sq_c4[0]) + SQRT_W'(sq_c4[1]) + SQRT_W'(sq_c4[2]);
	end

	always_comb begin
		logic [CMP_W-1:0] absv;
		logic [CMP_W:0]   rnd;
		logic [MAGX_W-1:0] magx;
		sat_e3 = 1'b0;
		for (int i = 0; i < 3; i++) begin
			absv      = comp_c2[i][CMP_W-1] ? (~comp_c2[i] + 1'b1) : comp_c2[i];
			rnd       = {1'b0, absv} + ((CMP_W+1)'(1) << (F - 1));
			magx      = MAGX_W'(rnd[CMP_W:F]);
			mag_e3[i] = magx[DIST_W-1:0];
			sat_e3    = sat_e3 | (|magx[MAGX_W-1:DIST_W]);
		end
	end

	// ---- root and output
	logic [ssd_pkg::ROOT_W-1:0] root_sq;
	logic                       sat_sq;

	ssd_sqrt u_sqrt (.clk(clk), .x(sum_c5), .root(root_sq));

	ssd_delay #(.WIDTH(1), .DEPTH(ssd_pkg::SQRT_STEPS)) u_dly_sat (
		.clk(clk),
		.d  (sat_c5),
		.q  (sat_sq)
	);

	always_ff @(posedge clk) begin
		if (sat_sq || root_sq > ssd_pkg::ROOT_W'(ssd_pkg::DIST_MAX)) begin
			distance_q <= ssd_pkg::DIST_MAX;
		end else begin
			distance_q <= root_sq[DIST_W-1:0];
		end
	end

	assign distance = distance_q;
	assign done     = vld_q[LAT-1];

	// ---- assertions
	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not produce a result at the pipeline latency");

	a_no_req_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without a matching request");

	a_sat_output: assert property (@(posedge clk) disable iff (!arst_n)
		sat_sq |=> distance == ssd_pkg::DIST_MAX)
		else $error("saturated closing vector did not give the maximum distance");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[UVW_LAT] |-> (sc <= ((F+1)'(1) << F) && tc <= ((F+1)'(1) << F)))
		else $error("segment parameter above one");

endmodule

### sv/ssd_delay.sv
// ----------------------------------------------------------------------------
// ssd_delay
// Fixed-depth shift line that aligns side data with a pipeline.
// ----------------------------------------------------------------------------
module ssd_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		tap_s[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

### sv/ssd_mul.sv
// ----------------------------------------------------------------------------
// ssd_mul
// Pipelined signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module ssd_mul #(
	parameter int W = 52
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int H = (W + 1) / 2;

	logic         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [W-1:0] ma_s1, mb_s1;
	logic [2*H-1:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [2*H-1:0] ll_s3, hh_s3;
	logic [2*H:0]   mid_s3;
	logic [2*W-1:0] sum_s4;

	logic [H-1:0] a_lo, a_hi, b_lo, b_hi;

	assign a_lo = ma_s1[H-1:0];
	assign b_lo = mb_s1[H-1:0];
	assign a_hi = H'(ma_s1[W-1:H]);
	assign b_hi = H'(mb_s1[W-1:H]);

	always_ff @(posedge clk) begin
		neg_s1 <= a[W-1] ^ b[W-1];
		ma_s1  <= a[W-1] ? (~a + 1'b1) : a;
		mb_s1  <= b[W-1] ? (~b + 1'b1) : b;

		neg_s2 <= neg_s1;
		ll_s2  <= a_lo * b_lo;
		lh_s2  <= a_lo * b_hi;
		hl_s2  <= a_hi * b_lo;
		hh_s2  <= a_hi * b_hi;

		neg_s3 <= neg_s2;
		ll_s3  <= ll_s2;
		hh_s3  <= hh_s2;
		mid_s3 <= (2*H+1)'(lh_s2) + (2*H+1)'(hl_s2);

		neg_s4 <= neg_s3;
		sum_s4 <= (2*W)'(ll_s3) + ((2*W)'(mid_s3) << H) + ((2*W)'(hh_s3) << (2*H));

		p <= neg_s4 ? $signed(~sum_s4 + 1'b1) : $signed(sum_s4);
	end

endmodule

### sv/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined clamped ratio n/d as unsigned Q1.F, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssd_div #(
	parameter int W = 107,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic signed [W-1:0] n,
	input  logic signed [W-1:0] d,
	output logic [F:0]          q
);

	logic [W-1:0] rem_s  [F+1];
	logic [W-1:0] den_s  [F+1];
	logic [F-1:0] quo_s  [F+1];
	logic         zero_s [F+1];
	logic         one_s  [F+1];

	always_ff @(posedge clk) begin
		rem_s[0]  <= n;
		den_s[0]  <= d;
		quo_s[0]  <= '0;
		zero_s[0] <= (n <= $signed(W'(0)));
		one_s[0]  <= (n >= d);
	end

	for (genvar k = 1; k <= F; k++) begin : g_step
		logic [W-1:0] dbl;
		logic         ge;

		assign dbl = {rem_s[k-1][W-2:0], 1'b0};
		assign ge  = dbl >= den_s[k-1];

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? (dbl - den_s[k-1]) : dbl;
			den_s[k]  <= den_s[k-1];
			quo_s[k]  <= {quo_s[k-1][F-2:0], ge};
			zero_s[k] <= zero_s[k-1];
			one_s[k]  <= one_s[k-1];
		end
	end

	always_comb begin
		if (zero_s[F]) begin
			q = '0;
		end else if (one_s[F]) begin
			q = (F+1)'(1) << F;
		end else begin
			q = {1'b0, quo_s[F]};
		end
	end

endmodule

### sv/ssd_sqrt.sv
// ----------------------------------------------------------------------------
// ssd_sqrt
// Pipelined bit-serial integer square root, one trial bit per stage.
// ----------------------------------------------------------------------------
module ssd_sqrt (
	input  logic                         clk,
	input  logic [ssd_pkg::SQRT_W-1:0]   x,
	output logic [ssd_pkg::ROOT_W-1:0]   root
);

	localparam int W     = ssd_pkg::SQRT_W;
	localparam int STEPS = ssd_pkg::SQRT_STEPS;

	logic [W-1:0] rem_s  [STEPS];
	logic [W-1:0] root_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [W-1:0] TRIAL_BIT = W'(1) << (ssd_pkg::SQRT_TOP - 2*k);

		logic [W-1:0] xin, rin, trial;

		if (k == 0) begin : g_first
			assign xin = x;
			assign rin = '0;
		end else begin : g_next
			assign xin = rem_s[k-1];
			assign rin = root_s[k-1];
		end

		assign trial = rin + TRIAL_BIT;

		always_ff @(posedge clk) begin
			if (xin >= trial) begin
				rem_s[k]  <= xin - trial;
				root_s[k] <= (rin >> 1) + TRIAL_BIT;
			end else begin
				rem_s[k]  <= xin;
				root_s[k] <= rin >> 1;
			end
		end
	end

	assign root = root_s[STEPS-1][ssd_pkg::ROOT_W-1:0];

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D segment-to-segment distance pipeline.
// Requests are sent in random bursts over several parallel-threshold settings.
// Each accepted request is run through a wide-integer predictor. Every done
// pulse is compared in order against the oldest predicted distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	typedef logic signed [23:0]  coord_t;
	typedef logic signed [191:0] wide_t;

	class dist_scoreboard;
		logic [ssd_pkg::EPS_W-1:0]  eps;
		logic [ssd_pkg::DIST_W-1:0] dist_q[$];
		int                         n_req, n_checked, n_err, n_sat, n_par;

		function new();
			eps = ssd_pkg::EPS_RESET;
		endfunction

		function wide_t wx(longint x);
			wide_t r;
			r = x;
			return r;
		endfunction

		function longint unsigned frac_ratio(wide_t n, wide_t dn);
			longint unsigned q;
			q = 0;
			if (n <= 0)
				return 0;
			if (n >= dn)
				return longint'(1) << ssd_pkg::PARAM_FRAC_DEF;
			for (int i = 0; i < ssd_pkg::PARAM_FRAC_DEF; i++) begin
				n = n + n;
				q = q << 1;
				if (n >= dn) begin
					n = n - dn;
					q = q | 1;
				end
			end
			return q;
		endfunction

		function longint unsigned root(longint unsigned x);
			longint unsigned res, bt;
			res = 0;
			bt = longint'(1) << ssd_pkg::SQRT_TOP;
			for (int i = 0; i < ssd_pkg::SQRT_STEPS; i++) begin
				if (x >= res + bt) begin
					x = x - (res + bt);
					res = (res >> 1) + bt;
				end else
					res = res >> 1;
				bt = bt >> 2;
			end
			return res;
		endfunction

		function logic [ssd_pkg::DIST_W-1:0] calc_distance(coord_t p[12]);
			longint u[3], v[3], w[3];
			wide_t a, b, c, d, e, det, sn, sd, tn, td, x;
			longint unsigned sc, tc, mag, sum, r;
			longint comp;
			for (int i = 0; i < 3; i++) begin
				u[i] = longint'(p[3+i]) - longint'(p[i]);
				v[i] = longint'(p[9+i]) - longint'(p[6+i]);
				w[i] = longint'(p[i]) - longint'(p[6+i]);
			end
			a = 0; b = 0; c = 0; d = 0; e = 0;
			for (int i = 0; i < 3; i++) begin
				a = a + wx(u[i]) * wx(u[i]);
				b = b + wx(u[i]) * wx(v[i]);
				c = c + wx(v[i]) * wx(v[i]);
				d = d + wx(u[i]) * wx(w[i]);
				e = e + wx(v[i]) * wx(w[i]);
			end
			det = a * c - b * b;
			sd = det;
			td = det;
			if (det < $signed({176'd0, eps})) begin
				n_par++;
				sn = 0; sd = 1; tn = e; td = c;
			end else begin
				sn = b * e - c * d;
				tn = a * e - b * d;
				if (sn < 0) begin
					sn = 0; tn = e; td = c;
				end else if (sn > sd) begin
					sn = sd; tn = e + b; td = c;
				end
			end
			if (tn < 0 || tn > td) begin
				if (tn < 0) begin
					tn = 0; x = -d;
				end else begin
					tn = td; x = b - d;
				end
				if (x < 0)
					sn = 0;
				else if (x > a)
					sn = sd;
				else begin
					sn = x; sd = a;
				end
			end
			sc = frac_ratio(sn, sd);
			tc = frac_ratio(tn, td);
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				comp = w[i] * (longint'(1) << ssd_pkg::PARAM_FRAC_DEF) + longint'(sc) * u[i]
					- longint'(tc) * v[i];
				mag = comp < 0 ? -comp : comp;
				mag = (mag + (longint'(1) << (ssd_pkg::PARAM_FRAC_DEF - 1)))
					>> ssd_pkg::PARAM_FRAC_DEF;
				if (mag >= (longint'(1) << 25))
					return ssd_pkg::DIST_MAX;
				sum = sum + mag * mag;
			end
			r = root(sum);
			return r > ssd_pkg::DIST_MAX ? ssd_pkg::DIST_MAX : r[ssd_pkg::DIST_W-1:0];
		endfunction

		function void note(coord_t p[12]);
			logic [ssd_pkg::DIST_W-1:0] dv;
			dv = calc_distance(p);
			if (dv == ssd_pkg::DIST_MAX)
				n_sat++;
			dist_q.push_back(dv);
			n_req++;
		endfunction

		function void check(logic [ssd_pkg::DIST_W-1:0] got);
			logic [ssd_pkg::DIST_W-1:0] exp_d;
			if (dist_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("%0t: unexpected result distance=%0d", $realtime, got);
				return;
			end
			exp_d = dist_q.pop_front();
			n_checked++;
			if (got !== exp_d) begin
				n_err++;
				if (n_err <= 10)
					$display("%0t: distance mismatch: expected %0d, got %0d",
						$realtime, exp_d, got);
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       cfg_we;
	logic [ssd_pkg::EPS_W-1:0]  cfg_wdata;
	coord_t                     req[12];
	logic                       done;
	logic [ssd_pkg::DIST_W-1:0] distance;

	dist_scoreboard sb;

	segment_segment_distance_3d u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.seg1_start_x (req[0]),
		.seg1_start_y (req[1]),
		.seg1_start_z (req[2]),
		.seg1_end_x   (req[3]),
		.seg1_end_y   (req[4]),
		.seg1_end_z   (req[5]),
		.seg2_start_x (req[6]),
		.seg2_start_y (req[7]),
		.seg2_start_z (req[8]),
		.seg2_end_x   (req[9]),
		.seg2_end_y   (req[10]),
		.seg2_end_z   (req[11]),
		.done         (done),
		.distance     (distance)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check(distance);
			if (start && !busy)
				sb.note(req);
		end
	end

	// one request, held until accepted
	task automatic send_req(coord_t p[12]);
		for (int i = 0; i < 12; i++)
			req[i] <= p[i];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	task automatic drain();
		idle_cycles(1);
		while (sb.dist_q.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_eps(logic [ssd_pkg::EPS_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.eps = val;
	endtask

	function automatic coord_t rnd_coord(int kind);
		case (kind)
			0:       return coord_t'($urandom);
			1:       return coord_t'($signed($urandom_range(2047, 0)) - 1024);
			2:       return $urandom_range(1) ? coord_t'(24'sh7FFFFF - $urandom_range(255))
				: coord_t'(24'sh800000 + $urandom_range(255));
			default: return coord_t'($signed($urandom_range(65535, 0)) - 32768);
		endcase
	endfunction

	task automatic gen_pair(output coord_t p[12]);
		int kind, sz, m;
		kind = $urandom_range(9);
		sz = (kind < 2) ? 0 : (kind < 4) ? 3 : (kind == 4) ? 2 : 1;
		for (int i = 0; i < 12; i++)
			p[i] = rnd_coord(sz);
		if (kind == 5 || kind == 6) begin
			// parallel or collinear pair
			m = $signed($urandom_range(6)) - 3;
			for (int i = 0; i < 3; i++)
				p[9+i] = coord_t'(p[6+i] + m * (p[3+i] - p[i]));
		end else if (kind == 7) begin
			for (int i = 0; i < 3; i++)
				p[3+i] = p[i];
			if ($urandom_range(1))
				for (int i = 0; i < 3; i++)
					p[9+i] = p[6+i];
		end else if (kind == 8) begin
			// nearly parallel
			for (int i = 0; i < 3; i++)
				p[9+i] = coord_t'(p[6+i] + (p[3+i] - p[i]) + $signed($urandom_range(2)) - 1);
		end
	endtask

	task automatic directed();
		coord_t p[12];
		coord_t mx, mn;
		mx = 24'sh7FFFFF;
		mn = 24'sh800000;
		foreach (p[i]) p[i] = 0;
		send_req(p);
		foreach (p[i]) p[i] = mx;
		send_req(p);
		foreach (p[i]) p[i] = mn;
		send_req(p);
		foreach (p[i]) p[i] = (i < 6) ? mx : mn;
		send_req(p);
		foreach (p[i]) p[i] = (i % 2) ? mx : mn;
		send_req(p);
		foreach (p[i]) p[i] = ((i / 3) % 2) ? mx : mn;
		send_req(p);
		foreach (p[i]) p[i] = ((i / 3) == 1 || (i / 3) == 2) ? mx : mn;
		send_req(p);
		// crossing segments
		p = '{-256, 0, 0, 256, 0, 0, 0, -256, 100, 0, 256, 100};
		send_req(p);
		// parallel, overlapping and disjoint
		p = '{0, 0, 0, 512, 0, 0, 100, 256, 0, 700, 256, 0};
		send_req(p);
		p = '{0, 0, 0, 512, 0, 0, 2000, 256, 0, 3000, 256, 0};
		send_req(p);
		p = '{0, 0, 0, 512, 0, 0, -3000, 256, 0, -2000, 256, 0};
		send_req(p);
		// anti-parallel
		p = '{0, 0, 0, 512, 0, 0, 700, 256, 0, 100, 256, 0};
		send_req(p);
		// both degenerate, one degenerate
		p = '{5, 6, 7, 5, 6, 7, -9, 3, 1, -9, 3, 1};
		send_req(p);
		p = '{5, 6, 7, 5, 6, 7, -900, 3, 1, 900, 30, 1};
		send_req(p);
		p = '{-900, 3, 1, 900, 30, 1, 5, 6, 7, 5, 6, 7};
		send_req(p);
		// closest points past each end of either segment
		p = '{0, 0, 0, 256, 0, 0, 1000, -300, 50, 1000, 300, 50};
		send_req(p);
		p = '{0, 0, 0, 256, 0, 0, -1000, -300, 50, -1000, 300, 50};
		send_req(p);
		p = '{0, 0, 0, 0, 256, 0, 100, 1000, 50, 300, 3000, -50};
		send_req(p);
		p = '{0, 0, 0, 0, 256, 0, 100, -1000, 50, 300, -3000, -50};
		send_req(p);
		// far apart, large distance
		p = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn};
		send_req(p);
		p = '{mx, 0, 0, mx, 1, 0, mn, 0, 0, mn, 0, 1};
		send_req(p);
		start <= 1'b0;
	endtask

	task automatic random_phase(int n);
		coord_t p[12];
		int sent, burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(40, 1);
			for (int k = 0; k < burst && sent < n; k++) begin
				gen_pair(p);
				send_req(p);
				sent++;
			end
			if ($urandom_range(3) != 0)
				idle_cycles($urandom_range(6, 1));
		end
		start <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		foreach (req[i]) req[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		random_phase(200);
		drain();
		write_eps('0);
		directed();
		random_phase(200);
		drain();
		write_eps(16'hFFFF);
		random_phase(200);
		drain();
		write_eps(ssd_pkg::EPS_W'($urandom));
		random_phase(200);
		drain();
		write_eps(ssd_pkg::EPS_RESET);
		random_phase(200);

		idle_cycles(1);
		while (sb.dist_q.size() != 0)
			@(posedge clk);
		repeat (70)
			@(posedge clk);

		$display("Covered %0d requests, %0d results checked, over five threshold settings.",
			sb.n_req, sb.n_checked);
		$display("Parallel path taken %0d times, saturated distance %0d times, %0d errors.",
			sb.n_par, sb.n_sat, sb.n_err);
		if (sb.n_err == 0 && sb.dist_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### filelist.f
sv/ssd_pkg.sv
sv/ssd_delay.sv
sv/ssd_mul.sv
sv/ssd_div.sv
sv/ssd_sqrt.sv
sv/segment_segment_distance_3d.sv
tb/tb_top.sv
